// File: rtl/mph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mph_pkg: moon phase shared definitions
// Constants, fixed-point scale factors, pipeline structs and the phase-name
// codes used across the moon phase pipeline.
// ----------------------------------------------------------------------------
package mph_pkg;

	// default configuration
	localparam int DEF_TILES    = 48;
	localparam int DEF_LIT_BITS = 16;

	// field widths
	localparam int TIME_W     = 32;
	localparam int PHASE_W    = 32;
	localparam int TILE_W     = 6;
	localparam int TILE_EXT_W = 9;   // holds any tile count up to 256
	localparam int CODE_W     = 3;

	// reference new moon, seconds since 1970
	localparam logic [32:0] EPOCH = 33'd947182440;

	// reciprocal of the synodic month in Q0.64 per second, rounded half up
	localparam logic [127:0] SYN_NUM   = 128'd10000 << 64;
	localparam logic [127:0] SYN_DEN   = 128'd25514428769;
	localparam logic [127:0] SYN_RECIP = (SYN_NUM + SYN_NUM + SYN_DEN) / (SYN_DEN + SYN_DEN);
	localparam logic [31:0]  RECIP_LO  = SYN_RECIP[31:0];
	localparam logic [10:0]  RECIP_HI  = SYN_RECIP[42:32];

	// pi/2 in Q0.32 scaling, quarter window in Q0.32 and unity in Q2.30
	localparam logic [32:0] HALF_PI_Q32  = 33'd6746518852;
	localparam logic [31:0] INSTANT_HALF = 32'd85899346;
	localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
	localparam logic [31:0] HALF_CYCLE   = 32'h8000_0000;

	// exact floor division of a 32-bit value by k*(k-1) style divisors:
	// q = (n * M) >> S with M = ceil(2^S / c), S = 32 + ceil(log2 c)
	localparam logic [32:0] DIV_M12  = 33'(((65'd1 << 36) + 65'd11)  / 65'd12);
	localparam logic [32:0] DIV_M30  = 33'(((65'd1 << 37) + 65'd29)  / 65'd30);
	localparam logic [32:0] DIV_M56  = 33'(((65'd1 << 38) + 65'd55)  / 65'd56);
	localparam logic [32:0] DIV_M90  = 33'(((65'd1 << 39) + 65'd89)  / 65'd90);
	localparam logic [32:0] DIV_M132 = 33'(((65'd1 << 40) + 65'd131) / 65'd132);
	localparam logic [32:0] DIV_M182 = 33'(((65'd1 << 40) + 65'd181) / 65'd182);

	// phase-name codes
	typedef enum logic [CODE_W-1:0] {
		PH_NEW       = 3'd0,
		PH_FIRST_QTR = 3'd1,
		PH_FULL      = 3'd2,
		PH_LAST_QTR  = 3'd3,
		PH_WAX_CRES  = 3'd4,
		PH_WAX_GIB   = 3'd5,
		PH_WAN_GIB   = 3'd6,
		PH_WAN_CRES  = 3'd7
	} phase_code_t;

	// cosine series state: x^2, last term, running sum (Q2.30)
	typedef struct packed {
		logic [31:0]        x2;
		logic [30:0]        term;
		logic signed [32:0] sum;
	} series_t;

	// per-word results that ride alongside the series
	typedef struct packed {
		logic [TILE_EXT_W-1:0] tile;
		logic                  inst_hit;
		phase_code_t           inst_code;
		logic                  waxing;
		logic                  upper;
	} side_t;

	// multiplier of the divisor for series term k
	function automatic logic [32:0] term_mul(input int k);
		logic [32:0] m;
		unique case (k)
			2:       m = DIV_M12;
			3:       m = DIV_M30;
			4:       m = DIV_M56;
			5:       m = DIV_M90;
			6:       m = DIV_M132;
			7:       m = DIV_M182;
			default: m = '0;
		endcase
		return m;
	endfunction

	// shift of the divisor for series term k
	function automatic int term_shift(input int k);
		int s;
		unique case (k)
			2:       s = 36;
			3:       s = 37;
			4:       s = 38;
			5:       s = 39;
			6:       s = 40;
			7:       s = 40;
			default: s = 0;
		endcase
		return s;
	endfunction

	// odd terms of the cosine series are subtracted
	function automatic logic term_sub(input int k);
		return (k % 2) == 1;
	endfunction

endpackage
`default_nettype wire

// File: rtl/mph_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mph_if: moon phase channel interfaces
// Valid/ready channels for the time word in and the result word out.
// ----------------------------------------------------------------------------
interface mph_in_if import mph_pkg::*;;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] unix_seconds;

	modport source (output valid, output unix_seconds, input ready);
	modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface mph_out_if import mph_pkg::*; #(
	parameter int LIT_BITS = DEF_LIT_BITS
);
	logic              valid;
	logic              ready;
	logic [LIT_BITS:0] lit_fraction;
	logic [TILE_W-1:0] tile_index;
	logic [CODE_W-1:0] phase_code;

	modport source (output valid, output lit_fraction, output tile_index,
		output phase_code, input ready);
	modport sink   (input valid, input lit_fraction, input tile_index,
		input phase_code, output ready);
endinterface
`default_nettype wire

// File: rtl/moon_phase_from_unix_time_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moon_phase_from_unix_time_core: mean synodic moon phase
// Turns a Unix time into lit fraction, nearest phase tile and phase name
// through a fixed-point pipeline with a seven-term cosine series.
//
//   channel | dir | word                                   | handshake
//   din     | in  | unix_seconds[31:0]                     | valid/ready
//   dout    | out | lit_fraction, tile_index, phase_code   | valid/ready
//
// Stages: 3 for the phase product, 4 for fold and angle, 2 per cosine term
// for terms 2 to 7, and 2 to close the sum and register the result.
// One word is accepted every cycle while dout is taken or empty.
// A stall at dout freezes every stage in place; din.ready drops with it.
// Reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module moon_phase_from_unix_time_core import mph_pkg::*; #(
	parameter int TILES    = DEF_TILES,
	parameter int LIT_BITS = DEF_LIT_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mph_in_if.sink     din,
	mph_out_if.source  dout
);

	localparam int NCELL = 6;

	localparam logic [LIT_BITS:0] LIT_FULL   = (LIT_BITS + 1)'(1) << LIT_BITS;
	localparam logic [LIT_BITS:0] LIT_HALF   = (LIT_BITS + 1)'(1) << (LIT_BITS - 1);
	localparam logic [LIT_BITS:0] LIT_EIGHTH = (LIT_BITS + 1)'(1) << (LIT_BITS - 3);

	logic          adv;
	logic          phase_valid;
	logic [31:0]   phase;
	logic          chain_valid  [NCELL+1];
	series_t       chain_series [NCELL+1];
	side_t         chain_side   [NCELL+1];
	logic          res_valid;
	logic [LIT_BITS:0] res_lit;
	logic [TILE_W-1:0] res_tile;
	phase_code_t   res_code;

	// whole pipeline moves when the output register is free or taken
	assign adv       = !res_valid || dout.ready;
	assign din.ready = adv;

	// phase from time
	mph_phase u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (din.valid),
		.unix_seconds (din.unix_seconds),
		.out_valid    (phase_valid),
		.phase        (phase)
	);

	// fold, angle, tile and instant windows
	mph_angle #(
		.TILES (TILES)
	) u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (phase_valid),
		.phase     (phase),
		.out_valid (chain_valid[0]),
		.series    (chain_series[0]),
		.side      (chain_side[0])
	);

	// cosine series terms 2 to 7
	for (genvar g = 0; g < NCELL; g++) begin : g_term
		mph_term_cell #(
			.K (g + 2)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.in_valid   (chain_valid[g]),
			.in_series  (chain_series[g]),
			.in_side    (chain_side[g]),
			.out_valid  (chain_valid[g+1]),
			.out_series (chain_series[g+1]),
			.out_side   (chain_side[g+1])
		);
	end

	// lit fraction, name and output register
	mph_lit_out #(
		.LIT_BITS (LIT_BITS)
	) u_lit_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (chain_valid[NCELL]),
		.in_series (chain_series[NCELL]),
		.in_side   (chain_side[NCELL]),
		.out_valid (res_valid),
		.lit       (res_lit),
		.tile      (res_tile),
		.code      (res_code)
	);

	assign dout.valid        = res_valid;
	assign dout.lit_fraction = res_lit;
	assign dout.tile_index   = res_tile;
	assign dout.phase_code   = res_code;

	// new moon words are nearly dark
	a_new_dark: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_code == PH_NEW |-> res_lit < LIT_EIGHTH)
		else $error("new moon word with large lit fraction");

	// full moon words are nearly fully lit
	a_full_bright: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_code == PH_FULL |-> res_lit > LIT_FULL - LIT_EIGHTH)
		else $error("full moon word with small lit fraction");

	// crescent words are at most half lit
	a_crescent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_code == PH_WAX_CRES || res_code == PH_WAN_CRES)
		|-> res_lit <= LIT_HALF)
		else $error("crescent word more than half lit");

	// gibbous words are at least half lit
	a_gibbous: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_code == PH_WAX_GIB || res_code == PH_WAN_GIB)
		|-> res_lit >= LIT_HALF)
		else $error("gibbous word less than half lit");

endmodule
`default_nettype wire

// File: rtl/mph_phase.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mph_phase: time to phase
// Offsets the time from the reference new moon and multiplies by the
// synodic reciprocal, keeping the 32 fraction bits as the phase (Q0.32).
// ----------------------------------------------------------------------------
module mph_phase import mph_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic [TIME_W-1:0]  unix_seconds,
	output logic                    out_valid,
	output logic [PHASE_W-1:0]      phase
);

	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [32:0]   diff_s1;
	logic                 zero_s1, zero_s2;
	logic [31:0]          lo_s2, hi_s2;
	logic [PHASE_W-1:0]   phase_s3;

	logic signed [32:0]   diff_c;
	logic signed [65:0]   prod_lo_c;
	logic signed [44:0]   prod_hi_c;

	// signed offset from the epoch
	assign diff_c = $signed({1'b0, unix_seconds}) - $signed(EPOCH);

	// split reciprocal product, only bits 63..32 of the sum matter
	assign prod_lo_c = diff_s1 * $signed({1'b0, RECIP_LO});
	assign prod_hi_c = diff_s1 * $signed({1'b0, RECIP_HI});

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1  <= diff_c;
			zero_s1  <= (unix_seconds == '0);
			lo_s2    <= prod_lo_c[63:32];
			hi_s2    <= prod_hi_c[31:0];
			zero_s2  <= zero_s1;
			phase_s3 <= zero_s2 ? '0 : lo_s2 + hi_s2;
		end
	end

	assign out_valid = valid_s3;
	assign phase     = phase_s3;

endmodule
`default_nettype wire

// File: rtl/mph_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mph_angle: fold, angle and side results
// Folds the phase to a quarter wave, forms the angle and its square, and
// works out the tile index and the instant-phase window on the way.
// ----------------------------------------------------------------------------
module mph_angle import mph_pkg::*; #(
	parameter int TILES = DEF_TILES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic [PHASE_W-1:0] phase,
	output logic                    out_valid,
	output series_t                 series,
	output side_t                   side
);

	localparam int TBITS = $clog2(TILES + 1);
	localparam int TPW   = PHASE_W + TBITS;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [30:0]         w_s1;
	logic                upper_s1, hit_s1, waxing_s1;
	phase_code_t         code_s1;
	logic [TPW-1:0]      tprod_s1;
	logic [30:0]         theta_s2;
	side_t               side_s2, side_s3, side_s4;
	logic [61:0]         thsq_s3;
	series_t             series_s4;

	logic [31:0]         u_c;
	logic                upper_c;
	logic [30:0]         w_c;
	logic                hit_c;
	phase_code_t         code_c;
	logic [TPW-1:0]      tround_c;
	logic [TBITS-1:0]    traw_c, twrap_c;
	logic [63:0]         thprod_c;
	logic [31:0]         x2_c;

	// fold to half wave, then to quarter wave
	always_comb begin
		u_c     = phase[31] ? 32'({1'b1, 32'd0} - {1'b0, phase}) : phase;
		upper_c = u_c > ONE_Q30;
		w_c     = upper_c ? 31'(HALF_CYCLE - u_c) : u_c[30:0];
	end

	// instant windows around the four quarter points, lowest wins
	always_comb begin
		logic [31:0] diff;
		logic [31:0] gap;
		hit_c  = 1'b0;
		code_c = PH_NEW;
		for (int k = 3; k >= 0; k--) begin
			diff = phase - (32'(k) << 30);
			gap  = (diff > HALF_CYCLE) ? 32'd0 - diff : diff;
			if (gap < INSTANT_HALF) begin
				hit_c  = 1'b1;
				code_c = phase_code_t'(CODE_W'(k));
			end
		end
	end

	// nearest tile, wrapped at the top
	assign tround_c = tprod_s1 + (TPW'(1) << (PHASE_W - 1));
	assign traw_c   = tround_c[TPW-1:PHASE_W];
	assign twrap_c  = (traw_c == TBITS'(TILES)) ? '0 : traw_c;

	// angle in Q2.30 and its square
	assign thprod_c = 64'(w_s1) * 64'(HALF_PI_Q32);
	assign x2_c     = thsq_s3[61:30];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1              <= w_c;
			upper_s1          <= upper_c;
			hit_s1            <= hit_c;
			code_s1           <= code_c;
			waxing_s1         <= ~phase[31];
			tprod_s1          <= TPW'(phase) * TPW'(TILES);
			theta_s2          <= thprod_c[62:32];
			side_s2.tile      <= TILE_EXT_W'(twrap_c);
			side_s2.inst_hit  <= hit_s1;
			side_s2.inst_code <= code_s1;
			side_s2.waxing    <= waxing_s1;
			side_s2.upper     <= upper_s1;
			thsq_s3           <= 62'(theta_s2) * 62'(theta_s2);
			side_s3           <= side_s2;
			series_s4.x2      <= x2_c;
			series_s4.term    <= x2_c[31:1];
			series_s4.sum     <= $signed({1'b0, ONE_Q30});
			side_s4           <= side_s3;
		end
	end

	assign out_valid = valid_s4;
	assign series    = series_s4;
	assign side      = side_s4;

endmodule
`default_nettype wire

// File: rtl/mph_term_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mph_term_cell: one cosine series term
// Folds the previous term into the sum, multiplies it by x^2 and divides
// by the term's constant divisor through an exact reciprocal product.
// ----------------------------------------------------------------------------
module mph_term_cell import mph_pkg::*; #(
	parameter int K = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    adv,
	input  wire logic    in_valid,
	input  wire series_t in_series,
	input  wire side_t   in_side,
	output logic         out_valid,
	output series_t      out_series,
	output side_t        out_side
);

	localparam logic [32:0] MUL      = term_mul(K);
	localparam int          SHIFT    = term_shift(K);
	localparam logic        SUB_PREV = term_sub(K - 1);

	logic                valid_s1, valid_s2;
	logic [62:0]         prod_s1;
	logic [31:0]         x2_s1;
	logic signed [32:0]  sum_s1;
	side_t               side_s1, side_s2;
	series_t             series_s2;

	logic signed [32:0]  sum_c;
	logic [31:0]         n_c;
	logic [64:0]         qprod_c;
	logic [64:0]         q_c;

	// previous term into the running sum
	assign sum_c = SUB_PREV ? in_series.sum - $signed({2'b00, in_series.term})
	                        : in_series.sum + $signed({2'b00, in_series.term});

	// floor division by the term divisor
	assign n_c     = prod_s1[61:30];
	assign qprod_c = 65'(n_c) * 65'(MUL);
	assign q_c     = qprod_c >> SHIFT;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1        <= 63'(in_series.term) * 63'(in_series.x2);
			x2_s1          <= in_series.x2;
			sum_s1         <= sum_c;
			side_s1        <= in_side;
			series_s2.x2   <= x2_s1;
			series_s2.term <= q_c[30:0];
			series_s2.sum  <= sum_s1;
			side_s2        <= side_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign out_series = series_s2;
	assign out_side   = side_s2;

endmodule
`default_nettype wire

// File: rtl/mph_lit_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mph_lit_out: lit fraction and phase name
// Closes the cosine sum with the last term and clamps it, then forms the
// lit fraction, the crescent/gibbous decision and the output register.
// ----------------------------------------------------------------------------
module mph_lit_out import mph_pkg::*; #(
	parameter int LIT_BITS = DEF_LIT_BITS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          in_valid,
	input  wire series_t       in_series,
	input  wire side_t         in_side,
	output logic               out_valid,
	output logic [LIT_BITS:0]  lit,
	output logic [TILE_W-1:0]  tile,
	output phase_code_t        code
);

	logic                valid_s1, valid_s2;
	logic [30:0]         cos_s1;
	side_t               side_s1;
	logic [LIT_BITS:0]   lit_s2;
	logic [TILE_W-1:0]   tile_s2;
	phase_code_t         code_s2;

	logic signed [32:0]  sum_c;
	logic [30:0]         cos_c;
	logic [31:0]         l31_c;
	logic [31:0]         lround_c;
	logic                gibbous_c;
	phase_code_t         code_c;

	// last term, then clamp to [0, 1]
	always_comb begin
		sum_c = in_series.sum - $signed({2'b00, in_series.term});
		priority if (sum_c < 0)
			cos_c = '0;
		else if (sum_c > $signed({1'b0, ONE_Q30}))
			cos_c = ONE_Q30[30:0];
		else
			cos_c = sum_c[30:0];
	end

	// lit fraction in Q0.31, rounded to the output scale
	assign l31_c     = cos_s1 == '0 ? ONE_Q30 :
	                   side_s1.upper ? ONE_Q30 + 32'(cos_s1) : ONE_Q30 - 32'(cos_s1);
	assign lround_c  = l31_c + (32'(1) << (30 - LIT_BITS));
	assign gibbous_c = side_s1.upper || (cos_s1 == '0);

	// phase name
	always_comb begin
		priority if (side_s1.inst_hit)
			code_c = side_s1.inst_code;
		else if (side_s1.waxing)
			code_c = gibbous_c ? PH_WAX_GIB : PH_WAX_CRES;
		else
			code_c = gibbous_c ? PH_WAN_GIB : PH_WAN_CRES;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s1  <= cos_c;
			side_s1 <= in_side;
			lit_s2  <= lround_c[31:31-LIT_BITS];
			tile_s2 <= side_s1.tile[TILE_W-1:0];
			code_s2 <= code_c;
		end
	end

	assign out_valid = valid_s2;
	assign lit       = lit_s2;
	assign tile      = tile_s2;
	assign code      = code_s2;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: moon phase core check
// Drives Unix times through the valid/ready input channel with bursty
// traffic, stalls the result channel on its own pattern, and compares every
// result word against a fixed-point phase, cosine, tile and name predictor.
// ----------------------------------------------------------------------------
module testbench;
	import mph_pkg::*;

	localparam int TILES    = 48;
	localparam int LIT_BITS = 16;

	// reference new moon and mean synodic month
	localparam logic [63:0]  MOON_EPOCH   = 64'd947182440;
	localparam real          SYNODIC_SEC  = 2551442.8769;
	localparam logic [127:0] MONTH_E4     = 128'd25514428769;
	// cycles per second in Q0.64, rounded half up
	localparam logic [127:0] CYCLE_RATE_W = ((128'd10000 << 65) + MONTH_E4) / (MONTH_E4 << 1);
	localparam logic [63:0]  CYCLE_RATE   = CYCLE_RATE_W[63:0];
	localparam logic [63:0]  QUARTER_TURN = 64'd1 << 30;
	localparam logic [31:0]  WINDOW_HALF  = 32'd85899346;
	localparam logic [63:0]  HALF_PI_FX   = 64'd6746518852;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_WORDS = 1100;
	localparam int TAIL_CYCLES  = 30;

	logic clk;
	logic arst_n;

	mph_in_if                      in_ch ();
	mph_out_if #(.LIT_BITS(LIT_BITS)) out_ch ();

	moon_phase_from_unix_time_core #(
		.TILES   (TILES),
		.LIT_BITS(LIT_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (in_ch),
		.dout  (out_ch)
	);

	// one expected result word
	typedef struct {
		logic [31:0]     unix_seconds;
		logic [LIT_BITS:0] lit;
		logic [TILE_W-1:0] tile;
		phase_code_t     code;
	} moon_word_t;

	// predicts each result word and matches it against the block output
	class phase_tracker;
		moon_word_t pending_words[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function logic [31:0] phase_of_time(logic [31:0] t);
			logic [63:0] delta;
			logic [63:0] prod;
			if (t == 32'd0)
				return 32'd0;
			delta = {32'd0, t} - MOON_EPOCH;
			prod  = delta * CYCLE_RATE;
			return prod[63:32];
		endfunction

		// cosine of a quarter-cycle phase, Q2.30 series clamped to [0, 1]
		static function logic [63:0] quarter_cosine(logic [63:0] w);
			logic [63:0] angle;
			logic [63:0] angle_sq;
			logic [63:0] term;
			longint      acc;
			angle    = (w * HALF_PI_FX) >> 32;
			angle_sq = (angle * angle) >> 30;
			term     = QUARTER_TURN;
			acc      = longint'(QUARTER_TURN);
			for (int k = 1; k <= 7; k++) begin
				term = ((term * angle_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
				if (k % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			if (acc > longint'(QUARTER_TURN))
				acc = longint'(QUARTER_TURN);
			return 64'(acc);
		endfunction

		static function moon_word_t predict_moon(logic [31:0] t);
			moon_word_t  w;
			phase_code_t instants[4];
			logic [31:0] p;
			logic [63:0] fold;
			logic [63:0] lit31;
			logic [63:0] lit_round;
			logic [63:0] tile_w;
			logic [31:0] diff;
			logic [31:0] gap;
			bit          hit;
			instants = '{PH_NEW, PH_FIRST_QTR, PH_FULL, PH_LAST_QTR};
			p = phase_of_time(t);
			// lit fraction from the folded half cycle
			fold = (p < HALF_CYCLE) ? {32'd0, p} : (64'h1_0000_0000 - {32'd0, p});
			if (fold <= QUARTER_TURN)
				lit31 = QUARTER_TURN - quarter_cosine(fold);
			else
				lit31 = QUARTER_TURN + quarter_cosine(64'h8000_0000 - fold);
			lit_round = (lit31 + (64'd1 << (30 - LIT_BITS))) >> (31 - LIT_BITS);
			// nearest tile, wrapped
			tile_w = ({32'd0, p} * 64'(TILES) + 64'h8000_0000) >> 32;
			if (tile_w >= 64'(TILES))
				tile_w = tile_w - 64'(TILES);
			// instant windows first, then crescent or gibbous
			hit = 0;
			w.code = PH_NEW;
			for (int k = 0; k < 4; k++) begin
				diff = p - (32'(k) << 30);
				gap  = (diff > HALF_CYCLE) ? (32'd0 - diff) : diff;
				if (!hit && gap < WINDOW_HALF) begin
					w.code = instants[k];
					hit = 1;
				end
			end
			if (!hit) begin
				if (p < HALF_CYCLE)
					w.code = (lit31 >= QUARTER_TURN) ? PH_WAX_GIB : PH_WAX_CRES;
				else
					w.code = (lit31 >= QUARTER_TURN) ? PH_WAN_GIB : PH_WAN_CRES;
			end
			w.unix_seconds = t;
			w.lit  = lit_round[LIT_BITS:0];
			w.tile = tile_w[TILE_W-1:0];
			return w;
		endfunction

		function void note_time(logic [31:0] t);
			pending_words.push_back(predict_moon(t));
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		task report(string what, logic [31:0] t, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: time %0d got %0d want %0d", what, t, got, want);
			mismatches++;
		endtask

		task check_word(logic [LIT_BITS:0] lit, logic [TILE_W-1:0] tile,
			logic [CODE_W-1:0] code);
			moon_word_t w;
			if (pending_words.size() == 0) begin
				report("unexpected word", 32'd0, 32'(lit), 32'd0);
				return;
			end
			w = pending_words.pop_front();
			if (lit !== w.lit)
				report("lit_fraction", w.unix_seconds, 32'(lit), 32'(w.lit));
			if (tile !== w.tile)
				report("tile_index", w.unix_seconds, 32'(tile), 32'(w.tile));
			if (code !== w.code)
				report("phase_code", w.unix_seconds, 32'(code), 32'(w.code));
		endtask
	endclass

	phase_tracker tracker = new();

	int results_seen;
	int idle_cycles;
	bit hold_done;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// offer one time word and wait for it to be taken
	task send_word(input logic [31:0] t);
		in_ch.valid        <= 1'b1;
		in_ch.unix_seconds <= t;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tracker.note_time(t);
	endtask

	// drop valid for a number of cycles
	task idle_for(input int n);
		in_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// time at a given quarter of the mean month, plus an offset in seconds
	function automatic logic [31:0] quarter_time(int quarter, int offset);
		real    r;
		longint s;
		r = real'(MOON_EPOCH) + real'(quarter) * SYNODIC_SEC / 4.0 + real'(offset);
		s = longint'(r);
		return s[31:0];
	endfunction

	// random time: uniform, near instants, near the edges, near the epoch
	function automatic logic [31:0] random_time();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 4)
			return $urandom;
		if (pick <= 7)
			return quarter_time(int'($urandom_range(0, 6735)) - 1485,
				int'($urandom_range(0, 140000)) - 70000);
		if (pick == 8)
			return $urandom_range(0, 1) ? $urandom_range(0, 16) :
				32'hFFFF_FFFF - $urandom_range(0, 16);
		return MOON_EPOCH[31:0] + $urandom_range(0, 4000) - 32'd2000;
	endfunction

	// stimulus and end of run
	initial begin
		logic [31:0] directed[$];
		int          burst_left;
		logic [31:0] centre;
		in_ch.valid        <= 1'b0;
		in_ch.unix_seconds <= '0;
		arst_n             <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero time, field extremes, epoch, both sides of each instant window
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, MOON_EPOCH[31:0], MOON_EPOCH[31:0] - 32'd1};
		for (int k = 0; k < 4; k++) begin
			centre = quarter_time(1200 + k, 0);
			directed.push_back(centre);
			directed.push_back(centre + 32'd51020);
			directed.push_back(centre + 32'd51040);
			directed.push_back(centre - 32'd51020);
			directed.push_back(centre - 32'd51040);
		end
		foreach (directed[i]) begin
			send_word(directed[i]);
			if (i % 7 == 6)
				idle_for($urandom_range(1, 5));
		end

		// random bursts with random gaps; one drain pause midway
		burst_left = $urandom_range(1, 40);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			send_word(random_time());
			if (i == RANDOM_WORDS / 2) begin
				in_ch.valid <= 1'b0;
				while (tracker.pending() != 0)
					@(posedge clk);
			end else begin
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					if ($urandom_range(0, 3) != 0)
						idle_for($urandom_range(1, 12));
				end
			end
		end
		in_ch.valid <= 1'b0;

		// drain and settle
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// result side: always ready, rotating pattern, or coin flips; one long hold
	initial begin
		int          mode;
		int          len;
		logic [7:0]  pat;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && results_seen >= 250) begin
				out_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
				hold_done = 1;
			end else begin
				mode = $urandom_range(0, 2);
				len  = $urandom_range(5, 60);
				pat  = 8'($urandom) | 8'h01;
				for (int c = 0; c < len; c++) begin
					case (mode)
						0: out_ch.ready <= 1'b1;
						1: out_ch.ready <= pat[c % 8];
						default: out_ch.ready <= 1'($urandom_range(0, 1));
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// result capture and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				tracker.check_word(out_ch.lit_fraction, out_ch.tile_index,
					out_ch.phase_code);
				results_seen++;
			end
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

endmodule
